### rtl/timestamped_event_record_replay_assert.svh
// Assertion macros for the trace buffer RTL.
// Depends on nothing; included inside module bodies.
`ifndef TIMESTAMPED_EVENT_RECORD_REPLAY_ASSERT_SVH
`define TIMESTAMPED_EVENT_RECORD_REPLAY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define TERR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("trace buffer check failed");

// Next-cycle implication, checked out of reset.
`define TERR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("trace buffer check failed");

`endif

### rtl/terr_pkg.sv
// Package for the timestamped event record and replay block.
// Holds tape sizing, request codes, sequencer states and memory request type.
`timescale 1ns / 1ps
package terr_pkg;

  localparam int TAPE_DEPTH = 4096;
  localparam int ADDR_W     = (TAPE_DEPTH > 1) ? $clog2(TAPE_DEPTH) : 1;
  localparam int CNT_W      = $clog2(TAPE_DEPTH + 1);
  localparam int OFF_W      = 32;
  localparam int PT_W       = 34;

  localparam logic [31:0] MAX_DUR_RESET = 32'd60000000;
  localparam logic [1:0]  KIND_TOGGLE   = 2'd3;

  typedef enum logic [2:0] {
    REQ_START_REC    = 3'd0,
    REQ_RECORD       = 3'd1,
    REQ_STOP_REC     = 3'd2,
    REQ_START_REPLAY = 3'd3,
    REQ_POLL         = 3'd4,
    REQ_STOP_REPLAY  = 3'd5
  } req_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] off_rd_addr;
    logic [ADDR_W-1:0] pt_rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
  } tape_req_t;

endpackage

### rtl/timestamped_event_record_replay.sv
// Top level of the timestamped event record and replay trace buffer.
// Instantiates terr_ctrl and two terr_ram tapes; uses terr_pkg.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. Its fields select
// one of start record, record event, stop record, start replay, poll replay
// and stop replay. Every request gives exactly one result, shown on the
// result ports for one cycle while result_valid_o is high, after the
// execute state. busy is high in the execute state that follows a request, so no
// new request is taken then, but one can be taken in the cycle in which
// the previous result is shown. The execute state uses registered tape reads:
// the entry at the replay position and the offset after it (the first one on
// start replay) are read in the request cycle and used in the following one.
// The receiver cannot stall; a result must be taken in the cycle it is shown.
// The duration limit is written on the cfg channel, which is always ready and
// should only be used while no request is in flight.
// Reset empties the tape, clears all flags and sets the duration limit to
// sixty seconds. The tape memories themselves are not cleared; only entries
// below the stored count are ever used.
module timestamped_event_record_replay (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 req_type_i,
  input  logic [31:0]                time_us_i,
  input  logic [15:0]                point_x_i,
  input  logic [15:0]                point_y_i,
  input  logic [1:0]                 event_kind_i,
  input  logic                       point_valid_i,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [31:0]                cfg_data_i,
  output logic                       result_valid_o,
  output logic                       accepted_o,
  output logic                       replay_valid_o,
  output logic [15:0]                replay_x_o,
  output logic [15:0]                replay_y_o,
  output logic [1:0]                 replay_kind_o,
  output logic [31:0]                replay_time_us_o,
  output logic [31:0]                next_offset_us_o,
  output logic                       next_offset_valid_o,
  output logic                       is_recording_o,
  output logic                       is_replaying_o,
  output logic                       overflowed_o,
  output logic [terr_pkg::CNT_W-1:0] stored_count_o
);
  import terr_pkg::*;

  tape_req_t        tape_req;
  logic [OFF_W-1:0] off_wdata, off_rdata;
  logic [PT_W-1:0]  pt_wdata, pt_rdata;

  assign cfg_ready_o = 1'b1;

  terr_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .req_type_i          (req_type_i),
    .time_us_i           (time_us_i),
    .point_x_i           (point_x_i),
    .point_y_i           (point_y_i),
    .event_kind_i        (event_kind_i),
    .point_valid_i       (point_valid_i),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_data_i          (cfg_data_i),
    .tape_req_o          (tape_req),
    .off_wdata_o         (off_wdata),
    .pt_wdata_o          (pt_wdata),
    .off_rdata_i         (off_rdata),
    .pt_rdata_i          (pt_rdata),
    .result_valid_o      (result_valid_o),
    .accepted_o          (accepted_o),
    .replay_valid_o      (replay_valid_o),
    .replay_x_o          (replay_x_o),
    .replay_y_o          (replay_y_o),
    .replay_kind_o       (replay_kind_o),
    .replay_time_us_o    (replay_time_us_o),
    .next_offset_us_o    (next_offset_us_o),
    .next_offset_valid_o (next_offset_valid_o),
    .is_recording_o      (is_recording_o),
    .is_replaying_o      (is_replaying_o),
    .overflowed_o        (overflowed_o),
    .stored_count_o      (stored_count_o)
  );

  terr_ram #(
    .WIDTH (OFF_W),
    .DEPTH (TAPE_DEPTH)
  ) u_offset_ram (
    .clk_i   (clk_i),
    .we_i    (tape_req.wr_en),
    .waddr_i (tape_req.wr_addr),
    .wdata_i (off_wdata),
    .re_i    (tape_req.rd_en),
    .raddr_i (tape_req.off_rd_addr),
    .rdata_o (off_rdata)
  );

  terr_ram #(
    .WIDTH (PT_W),
    .DEPTH (TAPE_DEPTH)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (tape_req.wr_en),
    .waddr_i (tape_req.wr_addr),
    .wdata_i (pt_wdata),
    .re_i    (tape_req.rd_en),
    .raddr_i (tape_req.pt_rd_addr),
    .rdata_o (pt_rdata)
  );

endmodule

### rtl/terr_ram.sv
// Generic single-clock RAM, one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module terr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic                                         re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/terr_ctrl.sv
// Sequencer and state of the trace buffer: request decode, tape pointers and flags.
// Depends on terr_pkg and the assertion macro header.
`timescale 1ns / 1ps
module terr_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [2:0]                  req_type_i,
  input  logic [31:0]                 time_us_i,
  input  logic [15:0]                 point_x_i,
  input  logic [15:0]                 point_y_i,
  input  logic [1:0]                  event_kind_i,
  input  logic                        point_valid_i,
  input  logic                        cfg_valid_i,
  input  logic [31:0]                 cfg_data_i,
  output terr_pkg::tape_req_t         tape_req_o,
  output logic [terr_pkg::OFF_W-1:0]  off_wdata_o,
  output logic [terr_pkg::PT_W-1:0]   pt_wdata_o,
  input  logic [terr_pkg::OFF_W-1:0]  off_rdata_i,
  input  logic [terr_pkg::PT_W-1:0]   pt_rdata_i,
  output logic                        result_valid_o,
  output logic                        accepted_o,
  output logic                        replay_valid_o,
  output logic [15:0]                 replay_x_o,
  output logic [15:0]                 replay_y_o,
  output logic [1:0]                  replay_kind_o,
  output logic [31:0]                 replay_time_us_o,
  output logic [31:0]                 next_offset_us_o,
  output logic                        next_offset_valid_o,
  output logic                        is_recording_o,
  output logic                        is_replaying_o,
  output logic                        overflowed_o,
  output logic [terr_pkg::CNT_W-1:0]  stored_count_o
);
  import terr_pkg::*;
  `include "timestamped_event_record_replay_assert.svh"

  state_e state_q, state_d;
  logic   accept;

  logic [2:0]  req_q;
  logic [31:0] time_q;
  logic [15:0] x_q, y_q;
  logic [1:0]  kind_q;
  logic        pvalid_q;

  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] pos_q, pos_d, pos_inc;
  logic [31:0]      rec_start_q, rec_start_d;
  logic [31:0]      rep_start_q, rep_start_d;
  logic             recording_q, recording_d;
  logic             replaying_q, replaying_d;
  logic             overflow_q, overflow_d;
  logic [31:0]      max_dur_q;
  logic [31:0]      head_q, head_d;
  logic [31:0]      target_q, target_d;

  logic             res_valid_q;
  logic             acc_q, acc_d;
  logic             rv_q, rv_d;
  logic [15:0]      rx_q, rx_d, ry_q, ry_d;
  logic [1:0]       rk_q, rk_d;
  logic [31:0]      rt_q, rt_d;

  logic             exec;
  logic             wr_en;
  logic [31:0]      rec_off;
  logic [31:0]      due_diff;
  logic             pending;

  assign accept  = start && (state_q == ST_IDLE);
  assign exec    = (state_q == ST_EXEC);
  assign pos_inc = pos_q + CNT_W'(1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b0;
    case (state_q)
      ST_IDLE: busy = 1'b0;
      ST_EXEC: busy = 1'b1;
      default: busy = 1'b1;
    endcase
  end

  always_comb begin
    tape_req_o.rd_en       = accept;
    tape_req_o.off_rd_addr = (req_type_i == REQ_START_REPLAY) ? '0 : pos_inc[ADDR_W-1:0];
    tape_req_o.pt_rd_addr  = pos_q[ADDR_W-1:0];
    tape_req_o.wr_en       = wr_en;
    tape_req_o.wr_addr     = count_q[ADDR_W-1:0];
  end

  assign off_wdata_o = rec_off;
  assign pt_wdata_o  = (kind_q == KIND_TOGGLE) ? {16'd0, 16'd0, kind_q} : {x_q, y_q, kind_q};
  assign rec_off     = time_q - rec_start_q;
  assign due_diff    = time_q - target_q;

  always_comb begin
    count_d     = count_q;
    pos_d       = pos_q;
    rec_start_d = rec_start_q;
    rep_start_d = rep_start_q;
    recording_d = recording_q;
    replaying_d = replaying_q;
    overflow_d  = overflow_q;
    head_d      = head_q;
    target_d    = target_q;
    wr_en       = 1'b0;
    acc_d       = 1'b0;
    rv_d        = 1'b0;
    rx_d        = '0;
    ry_d        = '0;
    rk_d        = '0;
    rt_d        = '0;
    if (exec) begin
      case (req_q)
        REQ_START_REC: begin
          count_d     = '0;
          pos_d       = '0;
          rec_start_d = time_q;
          recording_d = 1'b1;
          replaying_d = 1'b0;
          overflow_d  = 1'b0;
        end
        REQ_RECORD: begin
          if ((kind_q == KIND_TOGGLE || pvalid_q) && recording_q) begin
            if (count_q >= CNT_W'(TAPE_DEPTH) || rec_off > max_dur_q) begin
              overflow_d  = 1'b1;
              recording_d = 1'b0;
            end else begin
              wr_en   = 1'b1;
              acc_d   = 1'b1;
              count_d = count_q + CNT_W'(1);
            end
          end
        end
        REQ_STOP_REC: recording_d = 1'b0;
        REQ_START_REPLAY: begin
          recording_d = 1'b0;
          pos_d       = '0;
          rep_start_d = time_q;
          replaying_d = (count_q != '0);
          acc_d       = (count_q != '0);
          head_d      = off_rdata_i;
          target_d    = time_q + off_rdata_i;
        end
        REQ_POLL: begin
          if (pending && !due_diff[31]) begin
            rv_d     = 1'b1;
            rx_d     = pt_rdata_i[33:18];
            ry_d     = pt_rdata_i[17:2];
            rk_d     = pt_rdata_i[1:0];
            rt_d     = target_q;
            pos_d    = pos_inc;
            head_d   = off_rdata_i;
            target_d = rep_start_q + off_rdata_i;
            if (pos_inc == count_q) begin
              replaying_d = 1'b0;
            end
          end
        end
        REQ_STOP_REPLAY: begin
          replaying_d = 1'b0;
          pos_d       = '0;
        end
        default: ;
      endcase
    end
  end

  assign pending = replaying_q && (pos_q < count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      pos_q       <= '0;
      rec_start_q <= '0;
      rep_start_q <= '0;
      recording_q <= 1'b0;
      replaying_q <= 1'b0;
      overflow_q  <= 1'b0;
      max_dur_q   <= MAX_DUR_RESET;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pos_q       <= pos_d;
      rec_start_q <= rec_start_d;
      rep_start_q <= rep_start_d;
      recording_q <= recording_d;
      replaying_q <= replaying_d;
      overflow_q  <= overflow_d;
      res_valid_q <= exec;
      if (cfg_valid_i) begin
        max_dur_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q    <= req_type_i;
      time_q   <= time_us_i;
      x_q      <= point_x_i;
      y_q      <= point_y_i;
      kind_q   <= event_kind_i;
      pvalid_q <= point_valid_i;
    end
    head_q   <= head_d;
    target_q <= target_d;
    if (exec) begin
      acc_q <= acc_d;
      rv_q  <= rv_d;
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      rk_q  <= rk_d;
      rt_q  <= rt_d;
    end
  end

  assign result_valid_o      = res_valid_q;
  assign accepted_o          = acc_q;
  assign replay_valid_o      = rv_q;
  assign replay_x_o          = rx_q;
  assign replay_y_o          = ry_q;
  assign replay_kind_o       = rk_q;
  assign replay_time_us_o    = rt_q;
  assign next_offset_valid_o = pending;
  assign next_offset_us_o    = pending ? head_q : '0;
  assign is_recording_o      = recording_q;
  assign is_replaying_o      = replaying_q;
  assign overflowed_o        = overflow_q;
  assign stored_count_o      = count_q;

  `TERR_ASSERT_NEXT(a_exec_follows_accept, clk_i, rst_ni, accept, state_q == ST_EXEC)
  `TERR_ASSERT_NEXT(a_result_after_exec, clk_i, rst_ni, exec, res_valid_q && !exec)
  `TERR_ASSERT_NOW(a_count_bounded, clk_i, rst_ni, 1'b1, count_q <= CNT_W'(TAPE_DEPTH))
  `TERR_ASSERT_NOW(a_modes_exclusive, clk_i, rst_ni, recording_q, !replaying_q)

endmodule
